### hw/rtl/mafc_pkg.sv
// ----------------------------------------------------------------------------
// mafc_pkg
// shared constants and types of the moving average box filter
// ----------------------------------------------------------------------------
package mafc_pkg;

	// width of the window length register
	localparam int CFG_BITS = 6;

	// fractional bits of the average
	localparam int FRAC_BITS = 8;

	// depth of the queues on either side of the engine
	localparam int QUEUE_DEPTH = 2;

	// what the front makes of an incoming sample
	typedef enum logic [0:0] {
		OP_PUSH  = 1'b0,
		OP_FLUSH = 1'b1
	} op_kind_t;

	// engine sequencer
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SWEEP  = 6'b000010,
		ST_READ   = 6'b000100,
		ST_UPDATE = 6'b001000,
		ST_DIV    = 6'b010000,
		ST_OUT    = 6'b100000
	} eng_state_t;

endpackage

### hw/rtl/moving_average_full_convolution.sv
// ----------------------------------------------------------------------------
// moving_average_full_convolution
// Box-filter moving average over a profile of signed samples, as a full
// convolution with a box of length k. Every sample pushed gives one result,
// round(sum of the last k samples * 256 / k), signed with 8 fractional bits;
// samples before the start of a profile count as zero. A sample with
// sample_last set gives k results, the last k-1 computed with zeros fed in,
// and only the final one has result_last set; the window is then emptied for
// the next profile. k is the window length register (0 acts as 1, values
// above MAX_WINDOW act as MAX_WINDOW); write it only while the block is idle.
// Almost all of the time for each result is spent in the one-bit-per-cycle
// divider, and a last sample goes through it once per result. The first
// transaction after a change of k first resums the window. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module moving_average_full_convolution #(
	parameter int MAX_WINDOW  = 32,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// window length register
	input  logic                          cfg_we,
	input  logic [mafc_pkg::CFG_BITS-1:0] cfg_wdata,
	// sample side
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          sample_last,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS+mafc_pkg::FRAC_BITS-1:0] average,
	output logic                          result_last
);

	import mafc_pkg::*;

	localparam int K_W   = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (K_W > CFG_BITS) ? K_W : CFG_BITS;
	localparam int OUT_W = SAMPLE_BITS + FRAC_BITS;
	localparam int IN_W  = SAMPLE_BITS + 1;
	localparam int RES_W = OUT_W + 1;

	logic [CFG_BITS-1:0]     window_length_q;
	logic [CMP_W-1:0]        wl_ext;
	logic [K_W-1:0]          k_eff;

	// front: classified samples
	op_kind_t                in_kind;
	logic [IN_W-1:0]         in_wdata;
	logic [IN_W-1:0]         in_rdata;
	logic                    in_empty;
	logic                    in_pop;

	// back: results waiting to be taken
	logic                    res_push;
	logic                    res_full;
	logic [OUT_W-1:0]        res_average;
	logic                    res_last;
	logic [RES_W-1:0]        res_wdata;
	logic [RES_W-1:0]        res_rdata;

	// window length register, reset to a single-sample window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= CFG_BITS'(1);
		end else if (cfg_we) begin
			window_length_q <= cfg_wdata;
		end
	end

	// clamp to 1 .. MAX_WINDOW
	always_comb begin
		wl_ext = CMP_W'(window_length_q);
		if (wl_ext == '0) begin
			k_eff = K_W'(1);
		end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
			k_eff = K_W'(MAX_WINDOW);
		end else begin
			k_eff = wl_ext[K_W-1:0];
		end
	end

	// front: a last sample becomes a flush operation
	assign in_kind  = sample_last ? OP_FLUSH : OP_PUSH;
	assign in_wdata = {in_kind, sample};

	mafc_fifo #(
		.WIDTH (IN_W),
		.DEPTH (QUEUE_DEPTH)
	) u_front_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (in_wdata),
		.full   (full),
		.pop    (in_pop),
		.rdata  (in_rdata),
		.empty  (in_empty)
	);

	// back: window, running sum and division
	mafc_engine #(
		.MAX_WINDOW  (MAX_WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.k           (k_eff),
		.op_valid    (!in_empty),
		.op_kind     (op_kind_t'(in_rdata[SAMPLE_BITS])),
		.op_sample   (in_rdata[SAMPLE_BITS-1:0]),
		.op_pop      (in_pop),
		.res_full    (res_full),
		.res_push    (res_push),
		.res_average (res_average),
		.res_last    (res_last)
	);

	assign res_wdata = {res_last, res_average};

	// result queue decouples the engine from the consumer
	mafc_fifo #(
		.WIDTH (RES_W),
		.DEPTH (QUEUE_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wdata),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign average     = res_rdata[OUT_W-1:0];
	assign result_last = res_rdata[OUT_W];

endmodule

### hw/rtl/mafc_fifo.sv
// ----------------------------------------------------------------------------
// mafc_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module mafc_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_ok;
	logic             pop_ok;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/mafc_div.sv
// ----------------------------------------------------------------------------
// mafc_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mafc_div #(
	parameter int DIVIDEND_W = 25,
	parameter int DIVISOR_W  = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;
	logic [DIVISOR_W:0]    diff;

	// shift in the next dividend bit and try a subtraction
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		fits  = (trial >= {1'b0, divisor});
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DIVIDEND_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hw/rtl/mafc_engine.sv
// ----------------------------------------------------------------------------
// mafc_engine
// window store, running sum and rounded division for each result
// ----------------------------------------------------------------------------
module mafc_engine #(
	parameter int MAX_WINDOW  = 32,
	parameter int SAMPLE_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [$clog2(MAX_WINDOW+1)-1:0]    k,
	input  logic                               op_valid,
	input  mafc_pkg::op_kind_t                 op_kind,
	input  logic signed [SAMPLE_BITS-1:0]      op_sample,
	output logic                               op_pop,
	input  logic                               res_full,
	output logic                               res_push,
	output logic [SAMPLE_BITS+mafc_pkg::FRAC_BITS-1:0] res_average,
	output logic                               res_last
);

	import mafc_pkg::*;

	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int K_W    = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
	localparam int DIV_W  = SUM_W + FRAC_BITS;
	localparam int OUT_W  = SAMPLE_BITS + FRAC_BITS;

	eng_state_t                  state_q;
	logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]       valid_q;
	logic signed [SAMPLE_BITS-1:0] rd_data_q;
	logic                        rd_valid_q;
	logic [SLOT_W-1:0]           rd_addr;
	logic [SLOT_W-1:0]           slot_q;
	logic signed [SUM_W-1:0]     sum_q;
	logic [K_W-1:0]              k_q;
	logic signed [SAMPLE_BITS-1:0] cur_sample_q;
	logic                        last_q;
	logic [K_W-1:0]              remaining_q;
	logic [SLOT_W-1:0]           sweep_addr_q;
	logic [K_W-1:0]              sweep_cnt_q;
	logic                        sweep_pend_q;
	logic signed [SUM_W-1:0]     acc_q;
	logic                        neg_q;
	logic [OUT_W-1:0]            avg_q;

	logic signed [SAMPLE_BITS-1:0] entry;
	logic signed [SUM_W-1:0]     sum_next;
	logic [SUM_W-1:0]            sum_mag;
	logic [DIV_W-1:0]            dividend;
	logic [K_W:0]                slot_ext;
	logic [K_W:0]                k_ext;
	logic [K_W:0]                ev_ext;
	logic [SLOT_W-1:0]           ev_addr;
	logic                        sweep_issue;
	logic                        div_start;
	logic                        div_done;
	logic [DIV_W-1:0]            div_quo;
	logic [DIV_W-1:0]            quo_signed;
	logic                        mem_we;

	function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_W'(MAX_WINDOW - 1) : s - 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s + 1'b1;
	endfunction

	always_comb begin
		entry    = rd_valid_q ? rd_data_q : '0;
		sum_next = sum_q + SUM_W'(cur_sample_q) - SUM_W'(entry);
		sum_mag  = sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
		// round half away from zero: add k/2 before the division
		dividend = {sum_mag, {FRAC_BITS{1'b0}}} + DIV_W'(k >> 1);
		// oldest entry of the window, the one leaving it
		slot_ext = (K_W + 1)'(slot_q);
		k_ext    = (K_W + 1)'(k);
		ev_ext   = (slot_ext >= k_ext) ? slot_ext - k_ext
			: slot_ext + (K_W + 1)'(MAX_WINDOW) - k_ext;
		ev_addr  = ev_ext[SLOT_W-1:0];
		rd_addr  = (state_q == ST_SWEEP) ? sweep_addr_q : ev_addr;
		sweep_issue = (sweep_cnt_q != k);
		quo_signed  = neg_q ? (~div_quo + 1'b1) : div_quo;
	end

	assign div_start   = (state_q == ST_UPDATE);
	assign mem_we      = (state_q == ST_UPDATE);
	assign op_pop      = (state_q == ST_IDLE) && op_valid;
	assign res_push    = (state_q == ST_OUT) && !res_full;
	assign res_average = avg_q;
	assign res_last    = last_q && (remaining_q == '0);

	mafc_div #(
		.DIVIDEND_W (DIV_W),
		.DIVISOR_W  (K_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (k),
		.done     (div_done),
		.quotient (div_quo)
	);

	// window store, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= cur_sample_q;
		end
		rd_data_q  <= mem[rd_addr];
		rd_valid_q <= valid_q[rd_addr];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (op_pop) begin
			cur_sample_q <= op_sample;
		end else if (res_push && (remaining_q != '0)) begin
			cur_sample_q <= '0;
		end
		if (state_q == ST_UPDATE) begin
			neg_q <= sum_next[SUM_W-1];
		end
		if (div_done) begin
			avg_q <= quo_signed[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			slot_q       <= '0;
			sum_q        <= '0;
			k_q          <= K_W'(1);
			last_q       <= 1'b0;
			remaining_q  <= '0;
			sweep_addr_q <= '0;
			sweep_cnt_q  <= '0;
			sweep_pend_q <= 1'b0;
			acc_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (op_valid) begin
						last_q      <= (op_kind == OP_FLUSH);
						remaining_q <= (op_kind == OP_FLUSH) ? k - 1'b1 : '0;
						if (k != k_q) begin
							// window length changed: resum the newest k entries
							sweep_addr_q <= slot_prev(slot_q);
							sweep_cnt_q  <= '0;
							sweep_pend_q <= 1'b0;
							acc_q        <= '0;
							state_q      <= ST_SWEEP;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_SWEEP: begin
					if (sweep_issue) begin
						sweep_addr_q <= slot_prev(sweep_addr_q);
						sweep_cnt_q  <= sweep_cnt_q + 1'b1;
					end
					sweep_pend_q <= sweep_issue;
					if (sweep_pend_q) begin
						acc_q <= acc_q + SUM_W'(entry);
					end
					if (!sweep_issue && !sweep_pend_q) begin
						sum_q   <= acc_q;
						k_q     <= k;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					sum_q           <= sum_next;
					valid_q[slot_q] <= 1'b1;
					slot_q          <= slot_next(slot_q);
					state_q         <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_full) begin
						if (remaining_q != '0) begin
							remaining_q <= remaining_q - 1'b1;
							state_q     <= ST_READ;
						end else begin
							if (last_q) begin
								// end of profile: empty window
								valid_q <= '0;
								slot_q  <= '0;
								sum_q   <= '0;
							end
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the wait state");

	a_tail_only_on_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(remaining_q != '0) |-> last_q)
		else $error("tail results pending without a last sample");

	a_flush_clears_window: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && last_q && (remaining_q == '0))
		|=> ((valid_q == '0) && (slot_q == '0) && (sum_q == '0)))
		else $error("window not cleared after the final result");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ((k_q == k) && (k != '0)
			&& ((K_W + 1)'(k) <= (K_W + 1)'(MAX_WINDOW))))
		else $error("running sum kept for a different window length");
`endif

endmodule
